[rtl/core/asm_pkg.sv]
// Shared types and constants for the accelerometer scale and magnitude block.
package asm_pkg;

  localparam int unsigned AxisW   = 16;
  localparam int unsigned MagInW  = 14;
  localparam int unsigned SqW     = 27;
  localparam int unsigned RadW    = 28;
  localparam int unsigned RootW   = 14;
  localparam int unsigned RemW    = 16;
  localparam int unsigned OutW    = 19;
  localparam int unsigned RangeW  = 2;
  localparam int unsigned NumCells = RootW;

  // Per-sample data that rides along with the square-root chain.
  typedef struct packed {
    logic signed [OutW-1:0] x_scaled;
    logic signed [OutW-1:0] y_scaled;
    logic signed [OutW-1:0] z_scaled;
    logic                   last;
    logic [RangeW-1:0]      range_shift;
  } side_t;

  // State held by one square-root cell.
  typedef struct packed {
    logic [RadW-1:0]  rad;
    logic [RemW-1:0]  rem;
    logic [RootW-1:0] root;
    side_t            side;
  } cell_t;

endpackage

[rtl/core/asm_front.sv]
// Front stages: axis clearing and scaling, per-axis squares, sum of squares.
module asm_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            en_i,
  input  logic                            valid_i,
  input  logic [asm_pkg::AxisW-1:0]       x_raw_i,
  input  logic [asm_pkg::AxisW-1:0]       y_raw_i,
  input  logic [asm_pkg::AxisW-1:0]       z_raw_i,
  input  logic                            last_i,
  input  logic [asm_pkg::RangeW-1:0]      range_shift_i,
  output logic                            valid_o,
  output asm_pkg::cell_t                  data_o
);

  logic [asm_pkg::AxisW-1:0]  raw [3];
  logic [asm_pkg::OutW-1:0]   scaled [3];
  logic [asm_pkg::SqW-1:0]    sq_d [3];
  logic [asm_pkg::SqW-1:0]    sq_q [3];
  asm_pkg::side_t             side_d, side_q;
  logic                       vld1_q, vld2_q;
  asm_pkg::cell_t             cell_d, cell_q;

  assign raw[0] = x_raw_i;
  assign raw[1] = y_raw_i;
  assign raw[2] = z_raw_i;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      logic [asm_pkg::MagInW-1:0] u;
      logic [asm_pkg::MagInW-1:0] mag;
      logic [2*asm_pkg::MagInW-1:0] prod;
      logic signed [asm_pkg::OutW-1:0] ext;
      u    = raw[k][asm_pkg::AxisW-1:2];
      // 14-bit magnitude; the most negative code maps to 8192, which still fits
      mag  = u[asm_pkg::MagInW-1] ? (~u + 1'b1) : u;
      prod = mag * mag;
      sq_d[k] = prod[asm_pkg::SqW-1:0];
      ext  = asm_pkg::OutW'($signed({raw[k][asm_pkg::AxisW-1:2], 2'b00}));
      scaled[k] = ext << range_shift_i;
    end
  end

  always_comb begin
    side_d.x_scaled    = scaled[0];
    side_d.y_scaled    = scaled[1];
    side_d.z_scaled    = scaled[2];
    side_d.last        = last_i;
    side_d.range_shift = range_shift_i;
  end

  always_comb begin
    cell_d.rad  = asm_pkg::RadW'(sq_q[0]) + asm_pkg::RadW'(sq_q[1])
                + asm_pkg::RadW'(sq_q[2]);
    cell_d.rem  = '0;
    cell_d.root = '0;
    cell_d.side = side_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
    end else if (en_i) begin
      vld1_q <= valid_i;
      vld2_q <= vld1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sq_q   <= sq_d;
      side_q <= side_d;
      cell_q <= cell_d;
    end
  end

  assign valid_o = vld2_q;
  assign data_o  = cell_q;

endmodule

[rtl/core/asm_cell.sv]
// One square-root cell: brings in two radicand bits and decides one root bit.
module asm_cell (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  asm_pkg::cell_t data_i,
  output logic           valid_o,
  output asm_pkg::cell_t data_o
);

  logic [asm_pkg::RemW+1:0] rem_sh;
  logic [asm_pkg::RemW+1:0] trial;
  logic [asm_pkg::RemW+1:0] diff;
  logic                     take;
  asm_pkg::cell_t           cell_d, cell_q;
  logic                     vld_q;

  always_comb begin
    rem_sh = {data_i.rem, data_i.rad[asm_pkg::RadW-1 -: 2]};
    trial  = (asm_pkg::RemW+2)'({data_i.root, 2'b01});
    diff   = rem_sh - trial;
    take   = rem_sh >= trial;

    cell_d      = data_i;
    cell_d.rad  = {data_i.rad[asm_pkg::RadW-3:0], 2'b00};
    cell_d.rem  = take ? diff[asm_pkg::RemW-1:0] : rem_sh[asm_pkg::RemW-1:0];
    cell_d.root = {data_i.root[asm_pkg::RootW-2:0], take};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign valid_o = vld_q;
  assign data_o  = cell_q;

endmodule

[rtl/core/accel_sample_scale_magnitude.sv]
// Top level: accelerometer sample scaler with vector magnitude pipeline.
//
// Each sample's axes are cleared of their two low bits and shifted by the
// configured range; the vector magnitude is the floor square root of the sum
// of squares of the 14-bit axis values, shifted by two plus the range. The
// block takes one sample per clock while the chain is not held; each passes
// through two front stages (squares, then their sum) and a chain of 14
// square-root cells, one root bit per cell. The last cell is the output
// register; while a result waits on m_axis_tready the whole chain holds, and
// s_axis_tready is high whenever the output is empty or being taken. The
// range register is sampled when a sample enters and may be written at any
// time the block is idle; cfg_ready_o is always high.
module accel_sample_scale_magnitude (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_data_i,      // range_shift
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,    // x_raw[15:0], y_raw[31:16], z_raw[47:32]
  input  logic        s_axis_tlast,    // last_in_burst
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [79:0] m_axis_tdata,    // x_scaled[18:0], y_scaled[37:19],
                                       // z_scaled[56:38], magnitude[75:57], zero pad
  output logic        m_axis_tlast     // last_out
);

  logic [asm_pkg::RangeW-1:0] range_q;
  logic                       en;
  logic                       vld [asm_pkg::NumCells+1];
  asm_pkg::cell_t             chain [asm_pkg::NumCells+1];
  asm_pkg::cell_t             res;
  logic [2:0]                 mag_shift;
  logic [asm_pkg::OutW-1:0]   magnitude;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_q <= '0;
    end else if (cfg_valid_i) begin
      range_q <= cfg_data_i;
    end
  end

  // whole chain advances unless a finished result is stuck at the output
  assign en            = !vld[asm_pkg::NumCells] || m_axis_tready;
  assign s_axis_tready = en;

  asm_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (en),
    .valid_i       (s_axis_tvalid),
    .x_raw_i       (s_axis_tdata[15:0]),
    .y_raw_i       (s_axis_tdata[31:16]),
    .z_raw_i       (s_axis_tdata[47:32]),
    .last_i        (s_axis_tlast),
    .range_shift_i (range_q),
    .valid_o       (vld[0]),
    .data_o        (chain[0])
  );

  for (genvar i = 0; i < asm_pkg::NumCells; i++) begin : g_cell
    asm_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (vld[i]),
      .data_i  (chain[i]),
      .valid_o (vld[i+1]),
      .data_o  (chain[i+1])
    );
  end

  assign res       = chain[asm_pkg::NumCells];
  assign mag_shift = {1'b0, res.side.range_shift} + 3'd2;
  assign magnitude = asm_pkg::OutW'(res.root) << mag_shift;

  assign m_axis_tvalid = vld[asm_pkg::NumCells];
  assign m_axis_tlast  = res.side.last;
  assign m_axis_tdata  = {4'b0000, magnitude, res.side.z_scaled,
                          res.side.y_scaled, res.side.x_scaled};

  // a stalled chain keeps the occupancy of its first, middle and last stages
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> ($stable(vld[0]) && $stable(vld[asm_pkg::NumCells / 2])
             && $stable(vld[asm_pkg::NumCells])))
    else $error("pipeline occupancy changed during a stall");

  a_cfg_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |=> range_q == $past(cfg_data_i))
    else $error("range register not updated by a request");

  a_mag_low_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[58:57] == 2'b00)
    else $error("magnitude low bits not clear");

  a_mag_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> res.root <= asm_pkg::RootW'(14189))
    else $error("square root out of range");

endmodule
